@@ src/rgbhsv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Widths, stage count and pipeline payload types for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int PIX_W = 8;                // channel and result width
  localparam int Q_W   = 8;                // quotient bits, one per divider stage
  localparam int NUM_W = PIX_W + 3;        // hue numerator before scaling, < 6*255
  localparam int SR_W  = 2 * PIX_W;        // 255*diff
  localparam int HR_W  = NUM_W + PIX_W;    // 255*num
  localparam int HD_W  = NUM_W;            // 6*diff

  // first stage: channel max, spread and hue numerator
  typedef struct packed {
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] diff;
    logic [NUM_W-1:0] num;
  } prep_t;

  // divider stages: partial remainders, divisors and quotients of both divisions
  typedef struct packed {
    logic [PIX_W-1:0] mx;
    logic [SR_W-1:0]  rs;
    logic [PIX_W-1:0] ds;
    logic [HR_W-1:0]  rh;
    logic [HD_W-1:0]  dh;
    logic [Q_W-1:0]   qs;
    logic [Q_W-1:0]   qh;
  } div_t;

endpackage

@@ src/rgb_to_hsv_pixel.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// Converts one 8-bit RGB pixel to 8-bit hue, saturation and value through a
// pipeline of two setup stages and eight restoring-division stages.
// ----------------------------------------------------------------------------
// Channel   Ports                                         Direction
// input     in_valid, in_ready, in_red/green/blue         slave
// result    out_valid, out_ready, out_hue_out/sat/val     master
//
// One pixel per clock sustained while out_ready stays high; Q_W + 2 = 10
// register stages. The depth is set by the two dividers, which retire one
// quotient bit per stage in parallel.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so a stall on out_ready fills empty stages first.
// Reset (rst_n low, synchronous) empties every stage; no clearing pass.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rgbhsv_pkg::PIX_W-1:0] in_red,
  input  logic [rgbhsv_pkg::PIX_W-1:0] in_green,
  input  logic [rgbhsv_pkg::PIX_W-1:0] in_blue,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rgbhsv_pkg::PIX_W-1:0] out_hue_out,
  output logic [rgbhsv_pkg::PIX_W-1:0] out_sat_out,
  output logic [rgbhsv_pkg::PIX_W-1:0] out_val_out
);

  localparam int QW = rgbhsv_pkg::Q_W;
  localparam int PW = rgbhsv_pkg::PIX_W;
  localparam int NW = rgbhsv_pkg::NUM_W;

  // stage A: setup; stage 0: scaled operands; stages 1..QW: divider
  rgbhsv_pkg::prep_t prep_r, prep_nxt;
  logic              vld_a_r;
  rgbhsv_pkg::div_t  stg_r   [0:QW];
  rgbhsv_pkg::div_t  stg_nxt [0:QW];
  logic [QW:0]       vld_r;
  logic [QW+1:0]     rdy;
  logic              rdy_a;

  // ---- ready chain ---------------------------------------------------------
  always_comb begin
    rdy[QW+1] = out_ready;
    for (int i = QW; i >= 0; i--) begin
      rdy[i] = ~vld_r[i] | rdy[i+1];
    end
    rdy_a = ~vld_a_r | rdy[0];
  end

  assign in_ready = rdy_a;

  // ---- stage A: max, min, sector numerator ---------------------------------
  logic [PW-1:0] mx, mn, diff;
  logic [NW:0]   num_w;   // one spare bit for modular arithmetic
  logic [NW:0]   six_d;

  always_comb begin
    mx = (in_red > in_green) ? in_red : in_green;
    mx = (mx > in_blue) ? mx : in_blue;
    mn = (in_red < in_green) ? in_red : in_green;
    mn = (mn < in_blue) ? mn : in_blue;
    diff  = mx - mn;
    six_d = ((NW+1)'(diff) << 2) + ((NW+1)'(diff) << 1);
    priority if (in_blue == mx) begin
      num_w = ((NW+1)'(diff) << 2) + (NW+1)'(in_red) - (NW+1)'(in_green);
    end else if (in_green == mx) begin
      num_w = ((NW+1)'(diff) << 1) + (NW+1)'(in_blue) - (NW+1)'(in_red);
    end else begin
      num_w = (NW+1)'(in_green) - (NW+1)'(in_blue);
      // wrap a negative red-sector hue by a full turn
      if (in_green < in_blue) begin
        num_w = num_w + six_d;
      end
    end
    prep_nxt.mx   = mx;
    prep_nxt.diff = diff;
    prep_nxt.num  = num_w[NW-1:0];
  end

  // ---- stage 0: scale numerators by 255, build divisors ---------------------
  // a zero divisor only comes with a zero numerator; divide by one instead
  always_comb begin
    stg_nxt[0].mx = prep_r.mx;
    stg_nxt[0].rs = (rgbhsv_pkg::SR_W'(prep_r.diff) << PW) - rgbhsv_pkg::SR_W'(prep_r.diff);
    stg_nxt[0].ds = (prep_r.mx == '0) ? PW'(1) : prep_r.mx;
    stg_nxt[0].rh = (rgbhsv_pkg::HR_W'(prep_r.num) << PW) - rgbhsv_pkg::HR_W'(prep_r.num);
    stg_nxt[0].dh = (prep_r.diff == '0) ? rgbhsv_pkg::HD_W'(1)
                  : (rgbhsv_pkg::HD_W'(prep_r.diff) << 2) + (rgbhsv_pkg::HD_W'(prep_r.diff) << 1);
    stg_nxt[0].qs = '0;
    stg_nxt[0].qh = '0;
  end

  // ---- stages 1..QW: one quotient bit of each division ----------------------
  for (genvar j = 1; j <= QW; j++) begin : g_div
    localparam int K = QW - j;
    logic [rgbhsv_pkg::SR_W-1:0] sd;
    logic [rgbhsv_pkg::HR_W-1:0] hd;

    always_comb begin
      sd = rgbhsv_pkg::SR_W'(stg_r[j-1].ds) << K;
      hd = rgbhsv_pkg::HR_W'(stg_r[j-1].dh) << K;
      stg_nxt[j] = stg_r[j-1];
      if (stg_r[j-1].rs >= sd) begin
        stg_nxt[j].rs    = stg_r[j-1].rs - sd;
        stg_nxt[j].qs[K] = 1'b1;
      end
      if (stg_r[j-1].rh >= hd) begin
        stg_nxt[j].rh    = stg_r[j-1].rh - hd;
        stg_nxt[j].qh[K] = 1'b1;
      end
    end
  end

  // ---- registers -------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_r   <= '0;
    end else begin
      if (rdy_a) begin
        vld_a_r <= in_valid;
      end
      if (rdy[0]) begin
        vld_r[0] <= vld_a_r;
      end
      for (int i = 1; i <= QW; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      prep_r <= prep_nxt;
    end
    if (rdy[0] && vld_a_r) begin
      stg_r[0] <= stg_nxt[0];
    end
    for (int i = 1; i <= QW; i++) begin
      if (rdy[i] && vld_r[i-1]) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  assign out_valid   = vld_r[QW];
  assign out_hue_out = stg_r[QW].qh;
  assign out_sat_out = stg_r[QW].qs;
  assign out_val_out = stg_r[QW].mx;

`ifndef SYNTHESIS
  // a black pixel has no saturation and no hue
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_val_out == '0) |-> (out_sat_out == '0) && (out_hue_out == '0))
    else $error("black pixel with nonzero hue or saturation");

  // a transfer on the input lands in the setup stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_a_r)
    else $error("accepted pixel not held in setup stage");

  // a full stage 0 whose successor holds must keep its item
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] && !rdy[1] |=> vld_r[0] && $stable(stg_r[0]))
    else $error("stalled stage lost or changed its item");
`endif

endmodule
